/* src/bmprle_pkg.sv */
// ----------------------------------------------------------------------------
// bmprle_pkg
// Shared types and constants of the BMP RLE8/RLE4 pixel decoder.
// ----------------------------------------------------------------------------
package bmprle_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_ROWS_DEF  = 4096;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE_RLE4   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_ROWS  = 2'd2;

    // escape codes following a zero command byte
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef enum logic [6:0] {
        PH_CMD = 7'b0000001,
        PH_RUN = 7'b0000010,
        PH_ESC = 7'b0000100,
        PH_DX  = 7'b0001000,
        PH_DY  = 7'b0010000,
        PH_ABS = 7'b0100000,
        PH_PAD = 7'b1000000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] held_count;
        logic [7:0] absolute_left;
        logic       pad_pending;
        logic [7:0] held_x_offset;
        logic       finished;
    } ctrl_t;

    typedef struct packed {
        logic        valid;
        logic [23:0] span_start;
        logic [7:0]  span_length;
        logic [7:0]  index_even;
        logic [7:0]  index_odd;
        logic        image_done;
    } result_t;

endpackage

/* src/bmprle_decode.sv */
// ----------------------------------------------------------------------------
// bmprle_decode
// Next-state and span logic for one compressed byte.
// ----------------------------------------------------------------------------
module bmprle_decode #(
    parameter int POS_W = 26,
    parameter int EW_W  = 13
) (
    input  bmprle_pkg::ctrl_t   ctrl_in,
    input  logic [POS_W-1:0]    pos_in,
    input  logic [POS_W-1:0]    line_in,
    input  logic [POS_W-1:0]    lbase_in,
    input  logic [7:0]          data_byte,
    input  logic                start_image,
    input  logic [EW_W+7:0]     row_step,
    input  logic                mode_rle4,
    input  logic [EW_W-1:0]     width,
    input  logic [POS_W-1:0]    total,
    output bmprle_pkg::ctrl_t   ctrl_out,
    output logic [POS_W-1:0]    pos_out,
    output logic [POS_W-1:0]    line_out,
    output logic [POS_W-1:0]    lbase_out,
    output bmprle_pkg::result_t res
);

    localparam logic [POS_W-1:0] LBaseMax = {1'b0, {(POS_W-1){1'b1}}};

    bmprle_pkg::ctrl_t c;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  ln;
    logic [POS_W-1:0]  lb;
    logic [POS_W:0]    lb_sum;
    logic [7:0]        span_n;
    logic [7:0]        abs_n;
    logic [POS_W-1:0]  pos_span;
    logic [POS_W-1:0]  room;
    logic [7:0]        len;
    logic [7:0]        ev;
    logic [7:0]        od;
    logic [8:0]        b_inc;
    logic              complete;
    logic              stop;

    // span start is the position before this byte (zero after a fresh start)
    function automatic logic [23:0] pos_in_start(input logic [POS_W-1:0] p,
                                                 input logic s);
        logic [POS_W+23:0] ext;
        ext = {24'd0, p};
        return s ? 24'd0 : ext[23:0];
    endfunction

    always_comb
    begin
        c   = ctrl_in;
        pos = pos_in;
        ln  = line_in;
        lb  = lbase_in;
        if (start_image)
        begin
            c.phase         = bmprle_pkg::PH_CMD;
            c.held_count    = '0;
            c.absolute_left = '0;
            c.pad_pending   = 1'b0;
            c.held_x_offset = '0;
            c.finished      = 1'b0;
            pos = '0;
            ln  = '0;
            lb  = '0;
        end

        // pixels taken by this byte when it carries pixel data
        if (!mode_rle4)
            abs_n = 8'd1;
        else if (c.absolute_left >= 8'd2)
            abs_n = 8'd2;
        else
            abs_n = c.absolute_left;
        span_n   = (c.phase == bmprle_pkg::PH_RUN) ? c.held_count : abs_n;
        pos_span = pos + POS_W'(span_n);
        room     = total - pos;
        if (pos >= total)
            len = '0;
        else if (POS_W'(span_n) < room)
            len = span_n;
        else
            len = room[7:0];

        ev       = mode_rle4 ? {4'h0, data_byte[7:4]} : data_byte;
        od       = mode_rle4 ? {4'h0, data_byte[3:0]} : data_byte;
        b_inc    = {1'b0, data_byte} + 9'd1;
        lb_sum   = '0;
        complete = 1'b0;
        stop     = 1'b0;

        res             = '0;

        if (!c.finished)
        begin
            unique case (c.phase)
                bmprle_pkg::PH_CMD:
                begin
                    if (data_byte != 8'd0)
                    begin
                        c.held_count = data_byte;
                        c.phase      = bmprle_pkg::PH_RUN;
                    end
                    else
                    begin
                        c.phase = bmprle_pkg::PH_ESC;
                    end
                end
                bmprle_pkg::PH_RUN:
                begin
                    res.span_length = len;
                    pos             = pos_span;
                    complete        = 1'b1;
                end
                bmprle_pkg::PH_ESC:
                begin
                    priority if (data_byte == bmprle_pkg::ESC_EOL)
                    begin
                        ln     = ln + POS_W'(1);
                        lb_sum = {1'b0, lb} + (POS_W+1)'(width);
                        lb     = (lb_sum > (POS_W+1)'(LBaseMax)) ? LBaseMax : lb_sum[POS_W-1:0];
                        pos    = lb;
                        complete = 1'b1;
                    end
                    else if (data_byte == bmprle_pkg::ESC_EOB)
                    begin
                        stop = 1'b1;
                    end
                    else if (data_byte == bmprle_pkg::ESC_DELTA)
                    begin
                        c.phase = bmprle_pkg::PH_DX;
                    end
                    else
                    begin
                        c.absolute_left = data_byte;
                        c.pad_pending   = mode_rle4 ? b_inc[1] : data_byte[0];
                        c.phase         = bmprle_pkg::PH_ABS;
                    end
                end
                bmprle_pkg::PH_DX:
                begin
                    c.held_x_offset = data_byte;
                    c.phase         = bmprle_pkg::PH_DY;
                end
                bmprle_pkg::PH_DY:
                begin
                    ln     = ln + POS_W'(data_byte);
                    lb_sum = {1'b0, lb} + (POS_W+1)'(row_step);
                    lb     = (lb_sum > (POS_W+1)'(LBaseMax)) ? LBaseMax : lb_sum[POS_W-1:0];
                    pos    = pos + POS_W'(row_step) + POS_W'(c.held_x_offset);
                    complete = 1'b1;
                end
                bmprle_pkg::PH_ABS:
                begin
                    res.span_length = len;
                    pos             = pos_span;
                    c.absolute_left = c.absolute_left - abs_n;
                    if (c.absolute_left == 8'd0)
                    begin
                        if (c.pad_pending && (pos_span < total))
                            c.phase = bmprle_pkg::PH_PAD;
                        else
                            complete = 1'b1;
                    end
                end
                bmprle_pkg::PH_PAD:
                begin
                    complete = 1'b1;
                end
                default:
                begin
                    c.phase = bmprle_pkg::PH_CMD;
                end
            endcase

            if (complete)
            begin
                c.phase = bmprle_pkg::PH_CMD;
                if (pos >= total)
                    stop = 1'b1;
            end
            if (stop)
            begin
                c.finished = 1'b1;
                c.phase    = bmprle_pkg::PH_CMD;
            end

            res.valid      = (res.span_length != 8'd0) || stop;
            res.image_done = stop;
            if (res.span_length != 8'd0)
            begin
                res.span_start = pos_in_start(pos_in, start_image);
                res.index_even = ev;
                res.index_odd  = od;
            end
        end
    end

    assign ctrl_out  = c;
    assign pos_out   = pos;
    assign line_out  = ln;
    assign lbase_out = lb;

endmodule

/* src/bmp_rle_pixel_decoder_core.sv */
// ----------------------------------------------------------------------------
// bmp_rle_pixel_decoder_core
// BMP RLE8/RLE4 stream decoder: one compressed byte in, at most one span out.
// ----------------------------------------------------------------------------
//
//  channel   signals                                    direction
//  -------   ----------------------------------------   ---------
//  input     in_valid/in_ready, data_byte, start_image    in
//  result    out_valid/out_ready, span_start, span_length,
//            index_even, index_odd, image_done            out
//  config    cfg_write, cfg_index, cfg_data               in
//
//  One byte per clock unless a stalled result or config write holds input;
//  a span's byte passes the stage 1 register, then the result register.
//  Stage 1 registers the byte and its row step (byte * width product);
//  stage 2 updates decoder state and loads the result register.
//  A config write blocks input while image size and line base
//  are recomputed. Reset clears config to RLE8, 1x1 and the decoder state.
//  A stalled result register holds stage 2; stage 1 keeps one byte queued.
//
module bmp_rle_pixel_decoder_core #(
    parameter int MAX_WIDTH = bmprle_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = bmprle_pkg::MAX_ROWS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         data_byte,
    input  logic                               start_image,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [23:0]                        span_start,
    output logic [7:0]                         span_length,
    output logic [7:0]                         index_even,
    output logic [7:0]                         index_odd,
    output logic                               image_done,
    input  logic                               cfg_write,
    input  logic [bmprle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bmprle_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam longint MaxPixels = longint'(MAX_WIDTH) * longint'(MAX_ROWS);
    localparam int POS_W  = $clog2(MaxPixels + 256 * longint'(MAX_WIDTH) + 256) + 1;
    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int ER_W   = $clog2(MAX_ROWS + 1);
    localparam int PROD_W = EW_W + 8;
    localparam logic [POS_W-1:0] LBaseMax = {1'b0, {(POS_W-1){1'b1}}};

    // configuration
    logic              mode_reg;
    logic [EW_W-1:0]   eff_w_reg;
    logic [ER_W-1:0]   eff_r_reg;
    logic [POS_W-1:0]  total_reg;
    logic              cfg_hold_reg;
    logic [EW_W-1:0]   eff_w_next;
    logic [ER_W-1:0]   eff_r_next;

    // stage 1
    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic              s1_start_reg;
    logic [PROD_W-1:0] s1_prod_reg;

    // decoder state
    bmprle_pkg::ctrl_t ctrl_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  line_reg;
    logic [POS_W-1:0]  lbase_reg;

    bmprle_pkg::ctrl_t   ctrl_next;
    logic [POS_W-1:0]    pos_next;
    logic [POS_W-1:0]    line_next;
    logic [POS_W-1:0]    lbase_next;
    bmprle_pkg::result_t res;

    // result register
    logic              out_valid_reg;
    logic [23:0]       span_start_reg;
    logic [7:0]        span_length_reg;
    logic [7:0]        index_even_reg;
    logic [7:0]        index_odd_reg;
    logic              image_done_reg;

    logic                  in_fire;
    logic                  fire;
    logic [POS_W+EW_W-1:0] lbase_prod;
    logic [EW_W+ER_W-1:0]  total_prod;

    assign fire     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !cfg_write && !cfg_hold_reg && (!s1_valid_reg || fire);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        if (cfg_data == '0)
            eff_w_next = EW_W'(1);
        else if (32'(cfg_data) > 32'(MAX_WIDTH))
            eff_w_next = EW_W'(MAX_WIDTH);
        else
            eff_w_next = EW_W'(cfg_data);

        if (cfg_data == '0)
            eff_r_next = ER_W'(1);
        else if (32'(cfg_data) > 32'(MAX_ROWS))
            eff_r_next = ER_W'(MAX_ROWS);
        else
            eff_r_next = ER_W'(cfg_data);
    end

    assign total_prod = (EW_W+ER_W)'(eff_w_reg) * (EW_W+ER_W)'(eff_r_reg);
    assign lbase_prod = (POS_W+EW_W)'(line_reg) * (POS_W+EW_W)'(eff_w_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            eff_w_reg    <= EW_W'(1);
            eff_r_reg    <= ER_W'(1);
            total_reg    <= POS_W'(1);
            cfg_hold_reg <= 1'b0;
        end
        else
        begin
            cfg_hold_reg <= cfg_write;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bmprle_pkg::CFG_MODE_RLE4:   mode_reg  <= cfg_data[0];
                    bmprle_pkg::CFG_IMAGE_WIDTH: eff_w_reg <= eff_w_next;
                    bmprle_pkg::CFG_IMAGE_ROWS:  eff_r_reg <= eff_r_next;
                    default: ;
                endcase
            end
            if (cfg_hold_reg)
                total_reg <= POS_W'(total_prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg  <= data_byte;
            s1_start_reg <= start_image;
            s1_prod_reg  <= PROD_W'(data_byte) * PROD_W'(eff_w_reg);
        end
    end

    bmprle_decode #(
        .POS_W (POS_W),
        .EW_W  (EW_W)
    ) u_decode (
        .ctrl_in     (ctrl_reg),
        .pos_in      (pos_reg),
        .line_in     (line_reg),
        .lbase_in    (lbase_reg),
        .data_byte   (s1_byte_reg),
        .start_image (s1_start_reg),
        .row_step    (s1_prod_reg),
        .mode_rle4   (mode_reg),
        .width       (eff_w_reg),
        .total       (total_reg),
        .ctrl_out    (ctrl_next),
        .pos_out     (pos_next),
        .line_out    (line_next),
        .lbase_out   (lbase_next),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.phase         <= bmprle_pkg::PH_CMD;
            ctrl_reg.held_count    <= '0;
            ctrl_reg.absolute_left <= '0;
            ctrl_reg.pad_pending   <= 1'b0;
            ctrl_reg.held_x_offset <= '0;
            ctrl_reg.finished      <= 1'b0;
            pos_reg   <= '0;
            line_reg  <= '0;
            lbase_reg <= '0;
        end
        else if (fire)
        begin
            ctrl_reg  <= ctrl_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            lbase_reg <= lbase_next;
        end
        else if (cfg_hold_reg)
        begin
            // width may have changed: rebuild line start from line count
            if (lbase_prod > (POS_W+EW_W)'(LBaseMax))
                lbase_reg <= LBaseMax;
            else
                lbase_reg <= POS_W'(lbase_prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
        begin
            span_start_reg  <= res.span_start;
            span_length_reg <= res.span_length;
            index_even_reg  <= res.index_even;
            index_odd_reg   <= res.index_odd;
            image_done_reg  <= res.image_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign span_start  = span_start_reg;
    assign span_length = span_length_reg;
    assign index_even  = index_even_reg;
    assign index_odd   = index_odd_reg;
    assign image_done  = image_done_reg;

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !in_ready)
        else $error("input accepted right after a config write");

    a_done_silences: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ctrl_reg.finished && !s1_start_reg && out_ready) |=> !out_valid_reg)
        else $error("result produced after image end");

    a_empty_span_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (span_length_reg == 8'd0)) |-> image_done_reg)
        else $error("zero-length transaction without image_done");

    a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.valid && res.image_done) |=> ctrl_reg.finished)
        else $error("image_done issued but decoder not finished");

endmodule
